@@ design/local_binary_pattern_3x3_unit_macros.svh @@
// ---------------------------------------------------------------------------
// LBP 3x3 assertion macros
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LOCAL_BINARY_PATTERN_3X3_UNIT_MACROS_SVH
`define LOCAL_BINARY_PATTERN_3X3_UNIT_MACROS_SVH

`ifndef SYNTH
`define LBP3_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
	else $error("lbp3 assertion failed");
`define LBP3_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("lbp3 assertion failed");
`else
`define LBP3_ASSERT(lbl, clk, rstn, prop)
`define LBP3_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/lbp3_pkg.sv @@
// ---------------------------------------------------------------------------
// LBP 3x3 package
// Shared widths, register indexes, reset values and types.
// ---------------------------------------------------------------------------
package lbp3_pkg;

	localparam int PIX_W      = 8;
	localparam int CODE_W     = 8;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;
	localparam logic [IMG_H_W-1:0] MIN_HEIGHT       = 16'd3;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [CODE_W-1:0] code_t;

	typedef struct packed {
		logic emit;
		logic frame_end;
	} scan_tag_t;

endpackage

@@ design/lbp3_cfg.sv @@
// ---------------------------------------------------------------------------
// LBP 3x3 configuration registers
// Holds image width and height and presents the clamped frame geometry.
// ---------------------------------------------------------------------------
module lbp3_cfg #(
	parameter int MAX_WIDTH = 1024,
	parameter int CW        = $clog2(MAX_WIDTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lbp3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lbp3_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [CW-1:0]                     eff_width,
	output logic [lbp3_pkg::IMG_H_W-1:0]      eff_height
);
	import lbp3_pkg::*;

	logic [IMG_W_W-1:0] image_width_q;
	logic [IMG_H_W-1:0] image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(image_width_q) > 32'(MAX_WIDTH))
			eff_width = CW'(MAX_WIDTH);
		else if (image_width_q < 11'd3)
			eff_width = CW'(3);
		else
			eff_width = CW'(image_width_q);
	end

	assign eff_height = (image_height_q < MIN_HEIGHT) ? MIN_HEIGHT : image_height_q;

endmodule

@@ design/lbp3_scan.sv @@
// ---------------------------------------------------------------------------
// LBP 3x3 raster scan counters
// Column and row position of the incoming pixel, border and frame-end tags.
// ---------------------------------------------------------------------------
`include "local_binary_pattern_3x3_unit_macros.svh"

module lbp3_scan #(
	parameter int MAX_WIDTH = 1024,
	parameter int AW        = $clog2(MAX_WIDTH),
	parameter int CW        = $clog2(MAX_WIDTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [CW-1:0]                 eff_width,
	input  logic [lbp3_pkg::IMG_H_W-1:0]  eff_height,
	output logic [AW-1:0]                 col,
	output lbp3_pkg::scan_tag_t           tag
);
	import lbp3_pkg::*;

	logic [AW-1:0]      col_q;
	logic [IMG_H_W-1:0] row_q;
	logic               row_end;
	logic               frame_end;

	assign row_end   = ((CW+1)'(col_q) + (CW+1)'(1)) >= (CW+1)'(eff_width);
	assign frame_end = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, eff_height});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	assign col           = col_q;
	assign tag.emit      = (row_q >= 16'd2) && (32'(col_q) >= 32'd2);
	assign tag.frame_end = frame_end;

	`LBP3_ASSERT(a_col_in_store, clk, arst_n, 32'(col_q) < 32'(MAX_WIDTH))
	`LBP3_ASSERT_NEXT(a_frame_wrap, clk, arst_n, accept && frame_end, col_q == '0 && row_q == '0)
	`LBP3_ASSERT_NEXT(a_col_step, clk, arst_n, accept && !row_end, col_q == $past(col_q) + AW'(1))

endmodule

@@ design/lbp3_line_mem.sv @@
// ---------------------------------------------------------------------------
// LBP 3x3 line store
// Two previous rows packed per column: upper byte older row, lower newer.
// ---------------------------------------------------------------------------
module lbp3_line_mem #(
	parameter int MAX_WIDTH = 1024,
	parameter int AW        = $clog2(MAX_WIDTH)
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  rd_addr,
	output logic [2*lbp3_pkg::PIX_W-1:0]   rd_data,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [2*lbp3_pkg::PIX_W-1:0]   wr_data
);
	import lbp3_pkg::*;

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/lbp3_core.sv @@
// ---------------------------------------------------------------------------
// LBP 3x3 window and code stage
// Pixel stage, 3x3 window shift, neighbour compares and result register.
// ---------------------------------------------------------------------------
module lbp3_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int AW        = $clog2(MAX_WIDTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  lbp3_pkg::pix_t                 gray_pixel,
	input  logic [AW-1:0]                  col,
	input  lbp3_pkg::scan_tag_t            tag,
	output logic                           pixel_stall,
	input  logic [2*lbp3_pkg::PIX_W-1:0]   rd_data,
	output logic                           wr_en,
	output logic [AW-1:0]                  wr_addr,
	output logic [2*lbp3_pkg::PIX_W-1:0]   wr_data,
	output logic                           code_valid,
	input  logic                           code_stall,
	output lbp3_pkg::code_t                pattern_code,
	output logic                           frame_last
);
	import lbp3_pkg::*;

	logic      adv;
	logic      v_s1;
	scan_tag_t tag_s1;
	pix_t      px_s1;
	logic [AW-1:0] addr_s1;
	pix_t      win_q [6];
	pix_t      top;
	pix_t      mid;
	pix_t      ctr;
	code_t     code;
	logic      code_valid_q;
	code_t     pattern_code_q;
	logic      frame_last_q;

	assign adv         = !(code_valid_q && code_stall);
	assign pixel_stall = !adv;

	assign top = rd_data[2*PIX_W-1:PIX_W];
	assign mid = rd_data[PIX_W-1:0];
	assign ctr = win_q[3];

	assign wr_en   = v_s1 && adv;
	assign wr_addr = addr_s1;
	assign wr_data = {mid, px_s1};

	always_comb begin
		code[7] = win_q[0] > ctr;
		code[6] = win_q[1] > ctr;
		code[5] = top      > ctr;
		code[4] = win_q[2] > ctr;
		code[3] = mid      > ctr;
		code[2] = px_s1    > ctr;
		code[1] = win_q[5] > ctr;
		code[0] = win_q[4] > ctr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			tag_s1 <= '0;
		end else if (adv) begin
			v_s1 <= accept;
			if (accept)
				tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= gray_pixel;
			addr_s1 <= col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (v_s1 && adv) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top;
			win_q[2] <= win_q[3];
			win_q[3] <= mid;
			win_q[4] <= win_q[5];
			win_q[5] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			code_valid_q <= 1'b0;
		else if (adv)
			code_valid_q <= v_s1 && tag_s1.emit;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && tag_s1.emit) begin
			pattern_code_q <= code;
			frame_last_q   <= tag_s1.frame_end;
		end
	end

	assign code_valid   = code_valid_q;
	assign pattern_code = pattern_code_q;
	assign frame_last   = frame_last_q;

endmodule

@@ design/local_binary_pattern_3x3_unit.sv @@
// ---------------------------------------------------------------------------
// Local binary pattern 3x3 unit
// 8-bit raster pixels in, one 8-bit LBP code out per interior pixel.
// ---------------------------------------------------------------------------
//  channel   handshake             payload
//  cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//  pixel     pixel_valid/stall     gray_pixel
//  code      code_valid/stall      pattern_code, frame_last
//
//  One pixel item per clock sustained while no result is held on code_stall;
//  a completing pixel and its line store read are registered first, then
//  the compares load the result register that presents its code.
//  arst_n clears counters, window and valids; the line store is not cleared.
//  A held result on code_stall holds the pipeline and raises pixel_stall.
// ---------------------------------------------------------------------------
module local_binary_pattern_3x3_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbp3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbp3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            pixel_valid,
	output logic                            pixel_stall,
	input  logic [lbp3_pkg::PIX_W-1:0]      gray_pixel,
	output logic                            code_valid,
	input  logic                            code_stall,
	output logic [lbp3_pkg::CODE_W-1:0]     pattern_code,
	output logic                            frame_last
);
	import lbp3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic               accept;
	logic [CW-1:0]      eff_width;
	logic [IMG_H_W-1:0] eff_height;
	logic [AW-1:0]      col;
	scan_tag_t          tag;
	logic [2*PIX_W-1:0] rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [2*PIX_W-1:0] wr_data;

	assign accept = pixel_valid && !pixel_stall;

	lbp3_cfg #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.eff_width  (eff_width),
		.eff_height (eff_height)
	);

	lbp3_scan #(.MAX_WIDTH(MAX_WIDTH), .AW(AW), .CW(CW)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.eff_width  (eff_width),
		.eff_height (eff_height),
		.col        (col),
		.tag        (tag)
	);

	lbp3_line_mem #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lbp3_core #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.gray_pixel   (gray_pixel),
		.col          (col),
		.tag          (tag),
		.pixel_stall  (pixel_stall),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.pattern_code (pattern_code),
		.frame_last   (frame_last)
	);

endmodule
